/* hdl/accel_tilt_deviation_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for accel_tilt_deviation
// Shared assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_DEVIATION_ASSERT_SVH
`define ACCEL_TILT_DEVIATION_ASSERT_SVH

// assert that a condition implies a consequent in the same cycle
`define ATD_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("assertion failed");

// assert that a condition implies a consequent in the next cycle
`define ATD_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

/* hdl/atd_pkg.sv */
// ----------------------------------------------------------------------------
// atd_pkg
// Types and constants shared by the tilt deviation block.
// ----------------------------------------------------------------------------
`default_nettype none
package atd_pkg;

  localparam int CordicSteps = 22;
  localparam int CordicW = 46;
  localparam logic signed [CordicW-1:0] GainInv = 46'sd652032874;
  localparam logic signed [CordicW-1:0] Deg180 = 46'sd11796480;

  // register indexes
  localparam logic [2:0] RegOffX = 3'd0;
  localparam logic [2:0] RegOffY = 3'd1;
  localparam logic [2:0] RegOffZ = 3'd2;
  localparam logic [2:0] RegThr  = 3'd3;
  localparam logic [2:0] RegLev  = 3'd4;

  // CORDIC operating mode
  typedef enum logic {
    MODE_VEC,
    MODE_ROT
  } cmode_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_MAG,
    S_NORM,
    S_VEC,
    S_ANG,
    S_SIN,
    S_DEV,
    S_OUT
  } state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [CordicW-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 46'sd2949120;
      5'd1:  atan_lut = 46'sd1740967;
      5'd2:  atan_lut = 46'sd919879;
      5'd3:  atan_lut = 46'sd466945;
      5'd4:  atan_lut = 46'sd234379;
      5'd5:  atan_lut = 46'sd117304;
      5'd6:  atan_lut = 46'sd58666;
      5'd7:  atan_lut = 46'sd29335;
      5'd8:  atan_lut = 46'sd14668;
      5'd9:  atan_lut = 46'sd7334;
      5'd10: atan_lut = 46'sd3667;
      5'd11: atan_lut = 46'sd1833;
      5'd12: atan_lut = 46'sd917;
      5'd13: atan_lut = 46'sd458;
      5'd14: atan_lut = 46'sd229;
      5'd15: atan_lut = 46'sd115;
      5'd16: atan_lut = 46'sd57;
      5'd17: atan_lut = 46'sd29;
      5'd18: atan_lut = 46'sd14;
      5'd19: atan_lut = 46'sd7;
      5'd20: atan_lut = 46'sd4;
      5'd21: atan_lut = 46'sd2;
      default: atan_lut = '0;
    endcase
  endfunction

  // start command for the CORDIC unit
  typedef struct packed {
    logic                       start;
    cmode_t                     mode;
    logic signed [CordicW-1:0]  x;
    logic signed [CordicW-1:0]  y;
    logic signed [CordicW-1:0]  z;
  } ccmd_t;

  // result of the CORDIC unit
  typedef struct packed {
    logic                       done;
    logic signed [CordicW-1:0]  y;
    logic signed [CordicW-1:0]  z;
  } cres_t;

endpackage
`default_nettype wire

/* hdl/atd_isqrt.sv */
// ----------------------------------------------------------------------------
// atd_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module atd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;

  // one digit per cycle: compare, subtract, shift
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[1:0] != 2'b00) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = (rem >= trial && busy) ? 32'd0 : res[31:0];

endmodule
`default_nettype wire

/* hdl/atd_cordic.sv */
// ----------------------------------------------------------------------------
// atd_cordic
// Shared iterative CORDIC, vectoring or rotation, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module atd_cordic (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire atd_pkg::ccmd_t cmd,
  output atd_pkg::cres_t      res
);

  logic signed [atd_pkg::CordicW-1:0] x, y, z;
  logic [4:0]                         step;
  logic                               busy;
  logic                               finished;
  atd_pkg::cmode_t                    mode;
  logic                               dir;
  logic signed [atd_pkg::CordicW-1:0] xs, ys, at;

  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign at  = atd_pkg::atan_lut(step);
  assign dir = (mode == atd_pkg::MODE_VEC) ? (y > 0) : (z >= 0);

  // iterate up to CordicSteps steps; vectoring stops early once y reaches zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
        mode <= cmd.mode;
        if (cmd.mode == atd_pkg::MODE_VEC && cmd.x < 0) begin
          x <= -cmd.x;
          y <= -cmd.y;
          z <= (cmd.y >= 0) ? atd_pkg::Deg180 : -atd_pkg::Deg180;
        end else begin
          x <= cmd.x;
          y <= cmd.y;
          z <= cmd.z;
        end
      end else if (busy) begin
        if (mode == atd_pkg::MODE_VEC && y == 0) begin
          busy     <= 1'b0;
          finished <= 1'b1;
        end else begin
          if (dir) begin
            if (mode == atd_pkg::MODE_VEC) begin
              x <= x + ys;
              y <= y - xs;
              z <= z + at;
            end else begin
              x <= x - ys;
              y <= y + xs;
              z <= z - at;
            end
          end else begin
            if (mode == atd_pkg::MODE_VEC) begin
              x <= x - ys;
              y <= y + xs;
              z <= z - at;
            end else begin
              x <= x + ys;
              y <= y - xs;
              z <= z + at;
            end
          end
          step <= step + 5'd1;
          if (step == 5'(atd_pkg::CordicSteps - 1)) begin
            busy     <= 1'b0;
            finished <= 1'b1;
          end
        end
      end
    end
  end

  assign res = {finished, y, z};

endmodule
`default_nettype wire

/* hdl/accel_tilt_deviation.sv */
// ----------------------------------------------------------------------------
// accel_tilt_deviation
// Tilt angles and lever deviation from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// One sample is taken at a time; s_tready is low until its result has been
// taken, so a new sample cannot be accepted while one is in flight. The work
// goes to three squarings, the magnitude root and, when the sample is active
// (magnitude above the threshold), three norm roots on the shared bit-serial
// root unit and five vectoring passes on the shared CORDIC unit (shorter when
// y reaches zero early), and then three rotation passes with lever scaling.
// A quiet sample goes from the magnitude root straight to the rotation passes.
// An output stall holds the result, and the block, in S_OUT until m_tready.
`default_nettype none
module accel_tilt_deviation #(
  parameter int WINDOW_READINGS = 51,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // accel_x[19:0], accel_y[39:20], accel_z[59:40]
  input  wire logic [63:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // magnitude[20:0], tilt_x[36:21], tilt_y[52:37], tilt_z[68:53],
  // roll_angle[85:69], yaw_angle[101:86], dev_x[118:102], dev_y[135:119],
  // dev_z[152:136], sum_x[175:153], sum_y[198:176], sum_z[221:199]
  output logic [223:0]      m_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int W = atd_pkg::CordicW;
  localparam int Sh = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [W-1:0] Lim90  = W'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [W-1:0] Lim180 = W'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [W-1:0] Half   = W'(1) <<< (Sh - 1);

  // ---------------- configuration registers ----------------
  logic signed [19:0] offset_x, offset_y, offset_z;
  logic        [20:0] activity_threshold;
  logic        [15:0] lever_length;
  logic        [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      activity_threshold <= 21'd128000;
      lever_length <= 16'd32768;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        atd_pkg::RegOffX: offset_x <= pwdata[19:0];
        atd_pkg::RegOffY: offset_y <= pwdata[19:0];
        atd_pkg::RegOffZ: offset_z <= pwdata[19:0];
        atd_pkg::RegThr:  activity_threshold <= pwdata[20:0];
        atd_pkg::RegLev:  lever_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      atd_pkg::RegOffX: prdata = 32'(unsigned'(offset_x));
      atd_pkg::RegOffY: prdata = 32'(unsigned'(offset_y));
      atd_pkg::RegOffZ: prdata = 32'(unsigned'(offset_z));
      atd_pkg::RegThr:  prdata = 32'(activity_threshold);
      atd_pkg::RegLev:  prdata = 32'(lever_length);
      default:          prdata = '0;
    endcase
  end

  // ---------------- datapath state ----------------
  atd_pkg::state_t state, state_next;
  logic signed [20:0] c [3];
  logic        [41:0] sq [3];
  logic        [43:0] ssum;
  logic        [1:0]  k;        // axis or pass index
  logic        [2:0]  vpass;    // vectoring pass 0..4
  logic        [31:0] nrm [3];  // norms of other two axes, and of x,y
  logic        [20:0] mag;
  logic               active;
  logic signed [15:0] held_tilt [3];
  logic signed [16:0] held_roll;
  logic        [15:0] held_yaw;
  logic signed [16:0] dev [3];
  logic signed [22:0] deviation_sum [3];
  logic        [7:0]  window_count;
  logic signed [47:0] prod;
  logic        [1:0]  nidx;
  logic        [1:0]  nsel;
  logic signed [41:0] ck;
  logic               dev_ld;

  atd_pkg::ccmd_t ccmd;
  atd_pkg::cres_t cres;
  logic        sq_start, sq_done;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;

  atd_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  atd_cordic u_cordic (
    .clk(clk), .rst(rst), .cmd(ccmd), .res(cres)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= atd_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      atd_pkg::S_IDLE: if (s_tvalid) state_next = atd_pkg::S_SQ;
      atd_pkg::S_SQ:   if (k == 2'd2) state_next = atd_pkg::S_SQRT;
      atd_pkg::S_SQRT: state_next = atd_pkg::S_MAG;
      atd_pkg::S_MAG:  if (sq_done) begin
        state_next = active ? atd_pkg::S_NORM : atd_pkg::S_SIN;
      end
      atd_pkg::S_NORM: if (sq_done && nidx == 2'd2) state_next = atd_pkg::S_VEC;
      atd_pkg::S_VEC:  state_next = atd_pkg::S_ANG;
      atd_pkg::S_ANG:  if (cres.done) begin
        state_next = (vpass == 3'd4) ? atd_pkg::S_SIN : atd_pkg::S_VEC;
      end
      atd_pkg::S_SIN:  state_next = atd_pkg::S_DEV;
      // leave once the lever scaling of this axis has landed
      atd_pkg::S_DEV:  if (dev_ld) begin
        state_next = (k == 2'd2) ? atd_pkg::S_OUT : atd_pkg::S_SIN;
      end
      atd_pkg::S_OUT:  if (m_tready) state_next = atd_pkg::S_IDLE;
      default:         state_next = atd_pkg::S_IDLE;
    endcase
  end

  assign s_tready = (state == atd_pkg::S_IDLE);
  assign m_tvalid = (state == atd_pkg::S_OUT);

  // norm inputs for the root being started: (y,z), (z,x), (x,y)
  assign nsel = (state == atd_pkg::S_NORM) ? nidx + 2'd1 : 2'd0;

  logic signed [20:0] na, nb;
  always_comb begin
    case (nsel)
      2'd0:    begin na = c[1]; nb = c[2]; end
      2'd1:    begin na = c[2]; nb = c[0]; end
      default: begin na = c[0]; nb = c[1]; end
    endcase
  end

  logic signed [41:0] nae, nbe;
  assign nae = 42'(na);
  assign nbe = 42'(nb);

  logic [42:0] nsum;
  assign nsum = 43'(unsigned'(nae * nae)) + 43'(unsigned'(nbe * nbe));

  // root unit start
  always_comb begin
    sq_start = 1'b0;
    sq_rad   = 64'(ssum);
    if (state == atd_pkg::S_SQRT) sq_start = 1'b1;
    if (state == atd_pkg::S_MAG && sq_done && active) begin
      sq_start = 1'b1;
      sq_rad = {1'b0, nsum, 20'd0};
    end
    if (state == atd_pkg::S_NORM && sq_done && nidx != 2'd2) begin
      sq_start = 1'b1;
      sq_rad = {1'b0, nsum, 20'd0};
    end
  end

  // vectoring pass operands: tilt x,y,z then roll then yaw
  logic signed [W-1:0] vx, vy;
  always_comb begin
    vx = W'(nrm[0]);
    vy = W'(c[0]) <<< 10;
    case (vpass)
      3'd0: begin vx = W'(nrm[0]); vy = W'(c[0]) <<< 10; end
      3'd1: begin vx = W'(nrm[1]); vy = W'(c[1]) <<< 10; end
      3'd2: begin vx = W'(nrm[2]); vy = W'(c[2]) <<< 10; end
      3'd3: begin vx = W'(c[2]) <<< 10; vy = W'(c[1]) <<< 10; end
      default: begin vx = W'(c[2]) <<< 10; vy = W'(nrm[2]); end
    endcase
  end

  always_comb begin
    ccmd.start = 1'b0;
    ccmd.mode  = atd_pkg::MODE_VEC;
    ccmd.x     = vx;
    ccmd.y     = vy;
    ccmd.z     = '0;
    if (state == atd_pkg::S_VEC) ccmd.start = 1'b1;
    if (state == atd_pkg::S_SIN) begin
      ccmd.start = 1'b1;
      ccmd.mode  = atd_pkg::MODE_ROT;
      ccmd.x     = atd_pkg::GainInv;
      ccmd.y     = '0;
      ccmd.z     = W'(held_tilt[k]) <<< Sh;
    end
  end

  // rounded angle from the CORDIC result
  logic signed [W-1:0] ang;
  assign ang = (cres.z + Half) >>> Sh;

  function automatic logic signed [W-1:0] clampw(input logic signed [W-1:0] v,
      input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
    clampw = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // sq input: current axis sign-extended
  assign ck = 42'(c[k]);

  logic signed [W-1:0] devr;
  assign devr = clampw(W'((prod + 48'sd536870912) >>> 30), -W'(65535), W'(65535));
  logic signed [23:0] sumn;
  logic [7:0] wc0;
  assign wc0 = (window_count >= 8'(WINDOW_READINGS)) ? 8'd0 : window_count;
  assign sumn = ((wc0 == 8'd0) ? 24'sd0 : 24'(deviation_sum[k])) + 24'(devr);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held_tilt[i] <= '0;
        deviation_sum[i] <= '0;
      end
      held_roll <= '0;
      held_yaw <= '0;
      window_count <= '0;
      k <= '0;
      vpass <= '0;
      nidx <= '0;
    end else begin
      case (state)
        atd_pkg::S_IDLE: if (s_tvalid) begin
          c[0] <= 21'(signed'(s_tdata[19:0])) - 21'(offset_x);
          c[1] <= 21'(signed'(s_tdata[39:20])) - 21'(offset_y);
          c[2] <= 21'(signed'(s_tdata[59:40])) - 21'(offset_z);
          k <= '0;
        end
        atd_pkg::S_SQ: begin
          sq[k] <= ck * ck;
          k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        end
        atd_pkg::S_SQRT: begin
          active <= {2'b0, ssum} > 46'(activity_threshold) * 46'(activity_threshold);
          nidx <= '0;
        end
        atd_pkg::S_MAG: if (sq_done) begin
          mag <= (sq_root > 32'd2097151) ? 21'h1FFFFF : sq_root[20:0];
        end
        atd_pkg::S_NORM: if (sq_done) begin
          nrm[nidx] <= sq_root;
          nidx <= nidx + 2'd1;
          vpass <= '0;
        end
        atd_pkg::S_ANG: if (cres.done) begin
          case (vpass)
            3'd0, 3'd1, 3'd2: held_tilt[vpass[1:0]] <= 16'(clampw(
                clampw(ang, -Lim90, Lim90), -W'(32768), W'(32767)));
            3'd3: held_roll <= 17'(clampw(clampw(ang, -Lim180, Lim180),
                                       -W'(65536), W'(65535)));
            default: held_yaw <= 16'(clampw(clampw(ang, '0, Lim180), '0, W'(65535)));
          endcase
          vpass <= vpass + 3'd1;
        end
        atd_pkg::S_SIN: prod <= '0;
        atd_pkg::S_DEV: if (cres.done) begin
          prod <= 48'(signed'(cres.y[31:0])) * 48'(signed'({1'b0, lever_length}));
        end
        atd_pkg::S_OUT: if (m_tready) begin
          k <= '0;
        end
        default: ;
      endcase
      // lever scaling lands in the cycle after the rotation finishes, from the registered product
      if (dev_ld) begin
        dev[k] <= 17'(devr);
        deviation_sum[k] <= (sumn > 24'sd4194303) ? 23'sd4194303 :
                            (sumn < -24'sd4194304) ? 23'(-24'sd4194304) : 23'(sumn);
        if (k == 2'd2) begin
          window_count <= ((wc0 + 8'd1) >= 8'(WINDOW_READINGS)) ? 8'd0 : wc0 + 8'd1;
        end
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dev_ld <= 1'b0;
    else     dev_ld <= (state == atd_pkg::S_DEV) && cres.done;
  end

  assign ssum = 44'(sq[0]) + 44'(sq[1]) + 44'(sq[2]);

  // result packing
  assign m_tdata = {2'b0, deviation_sum[2], deviation_sum[1], deviation_sum[0],
                    dev[2], dev[1], dev[0], held_yaw, held_roll,
                    held_tilt[2], held_tilt[1], held_tilt[0], mag};

  // ---------------- assertions ----------------
`include "accel_tilt_deviation_assert.svh"
  `ATD_ASSERT_IMPL(a_ready_idle, s_tready, !m_tvalid)
  `ATD_ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid)
  `ATD_ASSERT_IMPL(a_window, 1'b1, window_count < 8'(WINDOW_READINGS))

endmodule
`default_nettype wire

/* tb/sv/accel_tilt_deviation_chk.sv */
// ----------------------------------------------------------------------------
// accel_tilt_deviation_chk
// Watches the sample and result streams and the register port, predicts each
// result from the accepted sample and the current register values, and
// compares it field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_deviation_chk #(
  parameter int WINDOW_READINGS = 51,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_tready,
  input  wire logic [63:0]   s_tdata,
  input  wire logic          m_tvalid,
  input  wire logic          m_tready,
  input  wire logic [223:0]  m_tdata,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  input  wire logic          pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TurnHalf = 180 * 65536;

  // atan(2^-i) in 1/65536 degree
  localparam longint AtanStep [22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  // register copies
  logic signed [19:0] offs [3];
  logic        [20:0] thresh;
  logic        [15:0] lever;

  // tilt state
  longint held_tilt [3];
  longint held_roll, held_yaw;
  longint dev_total [3];
  int     win_pos;

  logic [223:0] result_fifo [$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint n);
    longint r, bit_v;
    r = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >>> 1) + bit_v;
      end else begin
        r = r >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return r;
  endfunction

  // atan2(y, x) in 1/65536 degree by vectoring
  function automatic longint angle_of(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? TurnHalf : -TurnHalf;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 22 && y != 0; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += AtanStep[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= AtanStep[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint round_angle(longint z16);
    return (z16 + (longint'(1) << (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
  endfunction

  function automatic longint scaled_norm(longint a, longint b);
    return root_floor((a * a + b * b) << 20);
  endfunction

  // lever times sine of angle by rotation
  function automatic longint lever_sine(longint ang, longint lev);
    longint x, y, z, nx, ny;
    x = 652032874;
    y = 0;
    z = ang * (longint'(1) << (16 - ANGLE_FRAC_BITS));
    for (int i = 0; i < 22; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= AtanStep[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += AtanStep[i];
      end
      x = nx;
      y = ny;
    end
    return clip((lev * y + (longint'(1) << 29)) >>> 30, -65535, 65535);
  endfunction

  // advance the tilt state by one sample and pack the result
  function automatic logic [223:0] tilt_result(logic [63:0] smp);
    longint c [3];
    longint dv [3];
    longint sq, mag, base, lim90, lim180;
    logic [223:0] r;
    lim90 = longint'(90) << ANGLE_FRAC_BITS;
    lim180 = longint'(180) << ANGLE_FRAC_BITS;
    for (int k = 0; k < 3; k++)
      c[k] = longint'($signed(smp[20*k +: 20])) - longint'(offs[k]);
    sq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    mag = clip(root_floor(sq), 0, 2097151);
    if (sq > longint'(thresh) * longint'(thresh)) begin
      for (int k = 0; k < 3; k++)
        held_tilt[k] = clip(clip(round_angle(angle_of(
            scaled_norm(c[(k + 1) % 3], c[(k + 2) % 3]), c[k] * 1024)),
            -lim90, lim90), -32768, 32767);
      held_roll = clip(clip(round_angle(angle_of(c[2] * 1024, c[1] * 1024)),
                            -lim180, lim180), -65536, 65535);
      held_yaw = clip(clip(round_angle(angle_of(c[2] * 1024, scaled_norm(c[0], c[1]))),
                           0, lim180), 0, 65535);
    end
    if (win_pos >= WINDOW_READINGS) win_pos = 0;
    for (int k = 0; k < 3; k++) begin
      base = (win_pos == 0) ? 0 : dev_total[k];
      dv[k] = lever_sine(held_tilt[k], longint'(lever));
      dev_total[k] = clip(base + dv[k], -4194304, 4194303);
    end
    win_pos++;
    if (win_pos >= WINDOW_READINGS) win_pos = 0;
    r = '0;
    r[20:0] = mag[20:0];
    r[36:21] = held_tilt[0][15:0];
    r[52:37] = held_tilt[1][15:0];
    r[68:53] = held_tilt[2][15:0];
    r[85:69] = held_roll[16:0];
    r[101:86] = held_yaw[15:0];
    r[118:102] = dv[0][16:0];
    r[135:119] = dv[1][16:0];
    r[152:136] = dv[2][16:0];
    r[175:153] = dev_total[0][22:0];
    r[198:176] = dev_total[1][22:0];
    r[221:199] = dev_total[2][22:0];
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    logic [223:0] want;
    if (rst) begin
      offs[0] <= '0; offs[1] <= '0; offs[2] <= '0;
      thresh <= 21'd128000;
      lever <= 16'd32768;
      for (int k = 0; k < 3; k++) begin
        held_tilt[k] = 0;
        dev_total[k] = 0;
      end
      held_roll = 0;
      held_yaw = 0;
      win_pos = 0;
      result_fifo.delete();
      fail_count = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          atd_pkg::RegOffX: offs[0] <= pwdata[19:0];
          atd_pkg::RegOffY: offs[1] <= pwdata[19:0];
          atd_pkg::RegOffZ: offs[2] <= pwdata[19:0];
          atd_pkg::RegThr:  thresh <= pwdata[20:0];
          atd_pkg::RegLev:  lever <= pwdata[15:0];
          default: ;
        endcase
      end
      // predict from each accepted sample
      if (s_tvalid && s_tready) result_fifo.push_back(tilt_result(s_tdata));
      // compare each accepted result
      if (m_tvalid && m_tready) begin
        if (result_fifo.size() == 0) begin
          $error("result with no pending prediction");
          fail_count++;
        end else begin
          want = result_fifo.pop_front();
          compare_field("magnitude", want[20:0], m_tdata[20:0]);
          compare_field("tilt_x", $signed(want[36:21]), $signed(m_tdata[36:21]));
          compare_field("tilt_y", $signed(want[52:37]), $signed(m_tdata[52:37]));
          compare_field("tilt_z", $signed(want[68:53]), $signed(m_tdata[68:53]));
          compare_field("roll_angle", $signed(want[85:69]), $signed(m_tdata[85:69]));
          compare_field("yaw_angle", want[101:86], m_tdata[101:86]);
          compare_field("dev_x", $signed(want[118:102]), $signed(m_tdata[118:102]));
          compare_field("dev_y", $signed(want[135:119]), $signed(m_tdata[135:119]));
          compare_field("dev_z", $signed(want[152:136]), $signed(m_tdata[152:136]));
          compare_field("sum_x", $signed(want[175:153]), $signed(m_tdata[175:153]));
          compare_field("sum_y", $signed(want[198:176]), $signed(m_tdata[198:176]));
          compare_field("sum_z", $signed(want[221:199]), $signed(m_tdata[221:199]));
        end
      end
    end
    pending = result_fifo.size();
  end

endmodule
`default_nettype wire

/* tb/sv/accel_tilt_deviation_tb.sv */
// ----------------------------------------------------------------------------
// accel_tilt_deviation_tb
// Drives samples and register settings into the tilt deviation block with
// random gaps and result stalls; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_deviation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int RandomSamples = 1500;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [223:0]  m_tdata;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  int  fail_count;
  int  pending;
  bit  quiet_tail = 1'b0;
  int  idle_cycles = 0;

  always #4 clk = ~clk;

  accel_tilt_deviation u_dut (.*);

  accel_tilt_deviation_chk u_chk (.*);

  // stall the result side in random bursts
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      m_tready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // hold tvalid high from one sample to the next unless a gap is drawn
  task automatic send_sample(logic signed [19:0] ax, logic signed [19:0] ay,
                             logic signed [19:0] az);
    int n;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk);
    end
    s_tdata <= {4'b0, az, ay, ax};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all results, then allow the block to settle before a write
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [19:0] rand_axis();
    case ($urandom_range(0, 4))
      0: return 20'sh80000 + 20'($urandom_range(0, 3));
      1: return 20'sh7FFFF - 20'($urandom_range(0, 3));
      2: return 20'($urandom_range(0, 600) - 300);
      default: return 20'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [19:0] ax, ay, az;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero vector, extremes, quiet and active, each sign of x
    send_sample(20'sd0, 20'sd0, 20'sd0);
    send_sample(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_sample(20'sh80000, 20'sh80000, 20'sh80000);
    send_sample(20'sh7FFFF, 20'sd0, 20'sd0);
    send_sample(20'sh80000, 20'sd0, 20'sd0);
    send_sample(20'sd0, 20'sh80000, 20'sd0);
    send_sample(20'sd0, 20'sd0, 20'sh7FFFF);
    send_sample(20'sd0, 20'sd0, 20'sh80000);
    send_sample(-20'sd200000, 20'sd100000, -20'sd50000);
    send_sample(20'sd1000, 20'sd1000, 20'sd1000);
    send_sample(-20'sd300000, -20'sd1, 20'sd300000);
    send_sample(20'sd128000, 20'sd0, 20'sd0);
    send_sample(20'sd128001, 20'sd0, 20'sd0);
    drain();

    // extreme settings: offsets at both ends, zero threshold, full lever
    reg_write(atd_pkg::RegOffX, 32'h0007FFFF);
    reg_write(atd_pkg::RegOffY, 32'h00080000);
    reg_write(atd_pkg::RegOffZ, 32'h0007FFFF);
    reg_write(atd_pkg::RegThr, 32'd0);
    reg_write(atd_pkg::RegLev, 32'd65535);
    send_sample(20'sh80000, 20'sh7FFFF, 20'sh80000);
    send_sample(20'sh7FFFF, 20'sh80000, 20'sh7FFFF);
    send_sample(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_sample(20'sd0, 20'sd0, 20'sd0);
    drain();
    reg_write(atd_pkg::RegOffX, 32'd0);
    reg_write(atd_pkg::RegOffY, 32'd0);
    reg_write(atd_pkg::RegOffZ, 32'd0);
    reg_write(atd_pkg::RegThr, 32'h001FFFFF);
    reg_write(atd_pkg::RegLev, 32'd0);
    send_sample(20'sh80000, 20'sh80000, 20'sh80000);
    send_sample(20'sd12345, -20'sd9876, 20'sd400000);
    drain();

    // random phases, each with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(atd_pkg::RegOffX,
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000));
      reg_write(atd_pkg::RegOffY,
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000));
      reg_write(atd_pkg::RegOffZ,
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000));
      reg_write(atd_pkg::RegThr, ph == 5 ? 32'd128000 : $urandom_range(0, 300000));
      reg_write(atd_pkg::RegLev, $urandom());
      if (ph == 5) quiet_tail = 1'b1;
      for (int i = 0; i < RandomSamples / 6; i++) begin
        ax = rand_axis();
        ay = rand_axis();
        az = rand_axis();
        send_sample(ax, ay, az);
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* accel_tilt_deviation.f */
+incdir+hdl
hdl/atd_pkg.sv
hdl/atd_isqrt.sv
hdl/atd_cordic.sv
hdl/accel_tilt_deviation.sv
tb/sv/accel_tilt_deviation_chk.sv
tb/sv/accel_tilt_deviation_tb.sv
